// ===== src/bldp_pkg.sv =====
package bldp_pkg;

    localparam int MAX_OFFSET_BITS = 15;
    localparam int HISTORY_DEPTH   = 32768;
    localparam int MAX_BURST       = 64;
    localparam int LENGTH_BITS     = 24;
    localparam int FIELD_W         = 15;
    localparam int HIST_AW         = $clog2(HISTORY_DEPTH);
    localparam int CNT_W           = $clog2(MAX_BURST + 1);
    localparam int ADDR_W          = 5;

    typedef enum logic [2:0] {
        REG_OW_A   = 3'd0,
        REG_OW_B   = 3'd1,
        REG_OW_C   = 3'd2,
        REG_OW_D   = 3'd3,
        REG_SKIP   = 3'd4,
        REG_OUTLEN = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [3:0]             ow_a;
        logic [3:0]             ow_b;
        logic [3:0]             ow_c;
        logic [3:0]             ow_d;
        logic [7:0]             skip_count;
        logic [LENGTH_BITS-1:0] output_length;
    } cfg_t;

    typedef struct packed {
        logic       opcode;
        logic [7:0] packed_byte;
    } item_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic [23:0] out_position;
        logic        burst_last;
        logic        more_pending;
        logic        finished;
        logic        bad_reference;
    } result_t;

    function automatic logic [3:0] clamp_w(input logic [3:0] w);
        if (int'(w) > MAX_OFFSET_BITS)
            return 4'(MAX_OFFSET_BITS);
        return w;
    endfunction

    function automatic logic [LENGTH_BITS-1:0] sat_add(input logic [LENGTH_BITS-1:0] a,
                                                       input logic [LENGTH_BITS-1:0] b);
        logic [LENGTH_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s[LENGTH_BITS])
            return '1;
        return s[LENGTH_BITS-1:0];
    endfunction

endpackage

// ===== src/bldp_ram.sv =====
module bldp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32768
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata <= mem[raddr];
    end

endmodule

// ===== src/bldp_front.sv =====
module bldp_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  bldp_pkg::item_t in_item,
    output logic            q_valid,
    output bldp_pkg::item_t q_item,
    input  logic            q_pop
);
    import bldp_pkg::*;

    // two-entry queue between intake and decoder
    item_t      slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    logic       push;
    logic       pop;

    assign in_stall = (fill_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (fill_reg != 2'd0);
    assign q_item   = slot_reg[rd_ptr_reg];
    assign pop      = q_pop && q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            if (push && !pop)
                fill_reg <= fill_reg + 2'd1;
            else if (pop && !push)
                fill_reg <= fill_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= in_item;
    end

endmodule

// ===== src/bldp_back.sv =====
module bldp_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bldp_pkg::cfg_t    cfg,
    input  logic              q_valid,
    input  bldp_pkg::item_t   q_item,
    output logic              q_pop,
    output logic              out_valid,
    input  logic              out_stall,
    output bldp_pkg::result_t out_res
);
    import bldp_pkg::*;

    typedef enum logic [3:0] {
        PH_LOAD, PH_SKIP, PH_FLAG, PH_LITLEN, PH_LITBYTE, PH_INDEX,
        PH_LONGSEL, PH_OFFSET, PH_MATCHLEN, PH_COPY, PH_DONE
    } phase_t;

    typedef enum logic [1:0] {
        S_IDLE, S_RUN, S_READ
    } seq_t;

    seq_t                   st_reg;
    phase_t                 phase_reg;
    logic [7:0]             holder_reg;
    logic [3:0]             bits_reg;
    logic [7:0]             skip_reg;
    logic [FIELD_W-1:0]     fv_reg;
    logic [3:0]             fbl_reg;
    logic [LENGTH_BITS-1:0] rl_reg;
    logic [FIELD_W-1:0]     dist_reg;
    logic [LENGTH_BITS-1:0] br_reg;
    logic [CNT_W-1:0]       cnt_reg;
    logic                   ok_reg;
    logic                   pend_v_reg;
    result_t                pend_reg;
    logic                   ov_reg;
    result_t                out_reg;

    logic                   out_free;
    logic [LENGTH_BITS-1:0] pos_c;
    logic [LENGTH_BITS:0]   src_c;
    logic                   ok_c;
    logic                   at_cap;
    logic                   lit_emit;
    logic                   copy_emit;
    logic                   rd_issue;
    logic [7:0]             emit_byte;
    logic                   emit_bad;
    logic [7:0]             rdata;
    logic [LENGTH_BITS-1:0] rl_dec;
    logic                   step_end;
    logic                   push_out;
    result_t                last_res;

    assign out_free  = !ov_reg || !out_stall;
    assign pos_c     = br_reg - LENGTH_BITS'(1);
    assign rl_dec    = rl_reg - LENGTH_BITS'(1);
    assign src_c     = {1'b0, br_reg} + (LENGTH_BITS + 1)'(dist_reg);
    assign ok_c      = (src_c < {1'b0, cfg.output_length})
                       && (32'(dist_reg) < 32'(HISTORY_DEPTH));
    assign at_cap    = (int'(cnt_reg) >= MAX_BURST);
    assign lit_emit  = (st_reg == S_RUN) && out_free && (phase_reg == PH_LITBYTE)
                       && (fbl_reg == 4'd0) && !at_cap;
    assign copy_emit = (st_reg == S_READ) && out_free;
    assign rd_issue  = (st_reg == S_RUN) && out_free && (phase_reg == PH_COPY)
                       && (rl_reg != '0) && !at_cap;
    assign emit_byte = copy_emit ? (ok_reg ? rdata : 8'd0) : fv_reg[7:0];
    assign emit_bad  = copy_emit && !ok_reg;
    assign q_pop     = (st_reg == S_IDLE) && q_valid;
    assign out_valid = ov_reg;
    assign out_res   = out_reg;

    // step over: finished, burst cap hit, or out of held bits
    assign step_end  = (st_reg == S_RUN) && out_free
                       && (phase_reg == PH_DONE
                           || (phase_reg == PH_COPY && rl_reg != '0 && at_cap)
                           || (phase_reg == PH_SKIP && skip_reg != '0 && bits_reg == 4'd0)
                           || (phase_reg == PH_LITBYTE && fbl_reg == 4'd0 && at_cap)
                           || (phase_reg != PH_SKIP && phase_reg != PH_COPY
                               && phase_reg != PH_DONE && fbl_reg != 4'd0
                               && bits_reg == 4'd0));
    assign push_out  = pend_v_reg && (lit_emit || copy_emit || step_end);

    // held beat closing the step; more_pending only when the cap stopped it
    always_comb
    begin
        last_res              = pend_reg;
        last_res.burst_last   = 1'b1;
        last_res.more_pending = at_cap
                                && (phase_reg == PH_COPY
                                    || (phase_reg == PH_LITBYTE && fbl_reg == 4'd0));
    end

    bldp_ram #(
        .WIDTH (8),
        .DEPTH (HISTORY_DEPTH)
    ) u_hist (
        .clk   (clk),
        .we    (lit_emit || copy_emit),
        .waddr (pos_c[HIST_AW-1:0]),
        .wdata (emit_byte),
        .re    (rd_issue),
        .raddr (src_c[HIST_AW-1:0]),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            phase_reg  <= PH_LOAD;
            holder_reg <= '0;
            bits_reg   <= '0;
            skip_reg   <= '0;
            fv_reg     <= '0;
            fbl_reg    <= '0;
            rl_reg     <= '0;
            dist_reg   <= '0;
            br_reg     <= '0;
            cnt_reg    <= '0;
            ok_reg     <= 1'b0;
            pend_v_reg <= 1'b0;
            pend_reg   <= '0;
            ov_reg     <= 1'b0;
            out_reg    <= '0;
        end
        else
        begin
            if (push_out)
                ov_reg <= 1'b1;
            else if (!out_stall)
                ov_reg <= 1'b0;

            // a new result bumps the held one out as a non-final beat
            if (lit_emit || copy_emit)
            begin
                if (pend_v_reg)
                    out_reg <= pend_reg;
                pend_reg.out_byte      <= emit_byte;
                pend_reg.out_position  <= pos_c;
                pend_reg.burst_last    <= 1'b0;
                pend_reg.more_pending  <= 1'b0;
                pend_reg.finished      <= (pos_c == '0);
                pend_reg.bad_reference <= emit_bad;
                pend_v_reg             <= 1'b1;
                br_reg                 <= pos_c;
                cnt_reg                <= cnt_reg + CNT_W'(1);
                rl_reg                 <= rl_dec;
            end

            case (st_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        cnt_reg <= '0;
                        if (phase_reg == PH_LOAD)
                        begin
                            skip_reg  <= cfg.skip_count;
                            br_reg    <= cfg.output_length;
                            phase_reg <= (cfg.output_length == '0) ? PH_DONE : PH_SKIP;
                        end
                        if (!(phase_reg == PH_DONE
                              || (phase_reg == PH_LOAD && cfg.output_length == '0)))
                        begin
                            if (!q_item.opcode && bits_reg == 4'd0)
                            begin
                                holder_reg <= q_item.packed_byte;
                                bits_reg   <= 4'd8;
                            end
                            st_reg <= S_RUN;
                        end
                    end
                end

                S_READ:
                begin
                    if (out_free)
                    begin
                        if (pos_c == '0)
                            phase_reg <= PH_DONE;
                        st_reg <= S_RUN;
                    end
                end

                S_RUN:
                begin
                    if (out_free)
                    begin
                        // flush the held beat as the last one
                        if (step_end)
                        begin
                            if (pend_v_reg)
                                out_reg <= last_res;
                            pend_v_reg <= 1'b0;
                            st_reg     <= S_IDLE;
                        end
                        else if (phase_reg == PH_COPY)
                        begin
                            if (rl_reg == '0)
                            begin
                                phase_reg <= PH_FLAG;
                                fv_reg    <= '0;
                                fbl_reg   <= 4'd1;
                            end
                            else
                            begin
                                ok_reg <= ok_c;
                                st_reg <= S_READ;
                            end
                        end
                        else if (phase_reg == PH_SKIP)
                        begin
                            if (skip_reg == '0)
                            begin
                                phase_reg <= PH_FLAG;
                                fv_reg    <= '0;
                                fbl_reg   <= 4'd1;
                            end
                            else
                            begin
                                holder_reg <= holder_reg >> 1;
                                bits_reg   <= bits_reg - 4'd1;
                                skip_reg   <= skip_reg - 8'd1;
                            end
                        end
                        else if (fbl_reg == 4'd0)
                        begin
                            fv_reg <= '0;
                            case (phase_reg)
                                PH_FLAG:
                                begin
                                    if (!fv_reg[0])
                                    begin
                                        rl_reg    <= '0;
                                        phase_reg <= PH_LITLEN;
                                    end
                                    else
                                        phase_reg <= PH_INDEX;
                                    fbl_reg <= 4'd2;
                                end
                                PH_LITLEN:
                                begin
                                    if (fv_reg[1:0] == 2'd3)
                                    begin
                                        rl_reg  <= sat_add(rl_reg, LENGTH_BITS'(3));
                                        fbl_reg <= 4'd2;
                                    end
                                    else
                                    begin
                                        rl_reg    <= sat_add(sat_add(rl_reg,
                                                     LENGTH_BITS'(fv_reg[1:0])),
                                                     LENGTH_BITS'(1));
                                        phase_reg <= PH_LITBYTE;
                                        fbl_reg   <= 4'd8;
                                    end
                                end
                                PH_LITBYTE:
                                begin
                                    if (pos_c == '0)
                                        phase_reg <= PH_DONE;
                                    else if (rl_dec == '0)
                                    begin
                                        phase_reg <= PH_INDEX;
                                        fbl_reg   <= 4'd2;
                                    end
                                    else
                                        fbl_reg <= 4'd8;
                                end
                                PH_INDEX:
                                begin
                                    rl_reg <= LENGTH_BITS'(fv_reg[1:0]) + LENGTH_BITS'(1);
                                    case (fv_reg[1:0])
                                        2'd0:    fbl_reg <= clamp_w(cfg.ow_a);
                                        2'd1:    fbl_reg <= clamp_w(cfg.ow_b);
                                        2'd2:    fbl_reg <= clamp_w(cfg.ow_c);
                                        default: fbl_reg <= 4'd1;
                                    endcase
                                    phase_reg <= (fv_reg[1:0] == 2'd3) ? PH_LONGSEL
                                                                       : PH_OFFSET;
                                end
                                PH_LONGSEL:
                                begin
                                    phase_reg <= PH_OFFSET;
                                    fbl_reg   <= fv_reg[0] ? clamp_w(cfg.ow_d)
                                                           : clamp_w(4'd7);
                                end
                                PH_OFFSET:
                                begin
                                    dist_reg <= fv_reg;
                                    if (rl_reg == LENGTH_BITS'(4))
                                    begin
                                        phase_reg <= PH_MATCHLEN;
                                        fbl_reg   <= 4'd3;
                                    end
                                    else
                                    begin
                                        rl_reg    <= sat_add(rl_reg, LENGTH_BITS'(1));
                                        phase_reg <= PH_COPY;
                                    end
                                end
                                default:
                                begin
                                    if (fv_reg[2:0] == 3'd7)
                                    begin
                                        rl_reg  <= sat_add(rl_reg, LENGTH_BITS'(7));
                                        fbl_reg <= 4'd3;
                                    end
                                    else
                                    begin
                                        rl_reg    <= sat_add(sat_add(rl_reg,
                                                     LENGTH_BITS'(fv_reg[2:0])),
                                                     LENGTH_BITS'(1));
                                        phase_reg <= PH_COPY;
                                    end
                                end
                            endcase
                        end
                        else
                        begin
                            holder_reg <= holder_reg >> 1;
                            bits_reg   <= bits_reg - 4'd1;
                            fv_reg     <= {fv_reg[FIELD_W-2:0], holder_reg[0]};
                            fbl_reg    <= fbl_reg - 4'd1;
                        end
                    end
                end

                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_reg.finished |-> out_reg.burst_last)
        else $error("finishing beat not marked last");

    a_more_last: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && out_reg.more_pending |-> out_reg.burst_last)
        else $error("more_pending on a non-final beat");

    a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_READ |-> $past(st_reg == S_RUN) || $past(st_reg == S_READ))
        else $error("history read without issue");

    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == S_IDLE |-> !pend_v_reg)
        else $error("held beat left over between items");

endmodule

// ===== src/backward_lz_bitstream_depacker.sv =====
// Timing: an accepted beat is registered in the intake queue before the decoder
//   takes it; a step starts from idle, decodes the held bits one at a time, closes
//   each field (a literal leaves with its field), reads history through a registered
//   read before it writes each copied byte, and returns to idle to close the step.
// Throughput: one item at a time through the decoder sequencer.
// Reset: rst_n asynchronous, active low; decoder to load phase, history not cleared.
module backward_lz_bitstream_depacker (
    input  logic                         clk,
    input  logic                         rst_n,
    // packed byte channel
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic                         opcode,
    input  logic [7:0]                   packed_byte,
    // unpacked byte channel
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic [7:0]                   out_byte,
    output logic [23:0]                  out_position,
    output logic                         burst_last,
    output logic                         more_pending,
    output logic                         finished,
    output logic                         bad_reference,
    // register port
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bldp_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bldp_pkg::*;

    cfg_t     cfg_reg;
    item_t    in_item;
    item_t    q_item;
    logic     q_valid;
    logic     q_pop;
    result_t  res;
    reg_idx_t widx;
    logic     wr_en;

    assign pready = 1'b1;
    assign widx   = reg_idx_t'(paddr[4:2]);
    assign wr_en  = psel && penable && pwrite;

    // register file; the user is to write it only while the decoder is quiet, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ow_a          <= 4'd9;
            cfg_reg.ow_b          <= 4'd10;
            cfg_reg.ow_c          <= 4'd11;
            cfg_reg.ow_d          <= 4'd11;
            cfg_reg.skip_count    <= 8'd0;
            cfg_reg.output_length <= '0;
        end
        else if (wr_en)
        begin
            case (widx)
                REG_OW_A:   cfg_reg.ow_a          <= pwdata[3:0];
                REG_OW_B:   cfg_reg.ow_b          <= pwdata[3:0];
                REG_OW_C:   cfg_reg.ow_c          <= pwdata[3:0];
                REG_OW_D:   cfg_reg.ow_d          <= pwdata[3:0];
                REG_SKIP:   cfg_reg.skip_count    <= pwdata[7:0];
                REG_OUTLEN: cfg_reg.output_length <= pwdata[LENGTH_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        case (widx)
            REG_OW_A:   prdata = 32'(cfg_reg.ow_a);
            REG_OW_B:   prdata = 32'(cfg_reg.ow_b);
            REG_OW_C:   prdata = 32'(cfg_reg.ow_c);
            REG_OW_D:   prdata = 32'(cfg_reg.ow_d);
            REG_SKIP:   prdata = 32'(cfg_reg.skip_count);
            REG_OUTLEN: prdata = 32'(cfg_reg.output_length);
            default:    prdata = 32'd0;
        endcase
    end

    assign in_item.opcode      = opcode;
    assign in_item.packed_byte = packed_byte;

    // intake queue: takes beats while the decoder is busy
    bldp_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_item  (in_item),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop)
    );

    // bit decoder, history RAM and output register
    bldp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res)
    );

    assign out_byte      = res.out_byte;
    assign out_position  = res.out_position;
    assign burst_last    = res.burst_last;
    assign more_pending  = res.more_pending;
    assign finished      = res.finished;
    assign bad_reference = res.bad_reference;

endmodule

// ===== tb/tb_backward_lz_bitstream_depacker.sv =====
module tb_backward_lz_bitstream_depacker;
    import bldp_pkg::*;

    // run limit in clock cycles, well above the slowest legal run
    localparam int CYCLE_LIMIT = 1000000;
    // quiet time after the last expected beat, covering a 64 byte copy burst
    localparam int SETTLE      = 200;
    localparam int HOLD_CYCLES = 300;
    localparam int RAND_ITEMS  = 150;

    // opcodes of the packed byte channel
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_CONT = 1'b1;

    // decoder phases of the local model
    typedef enum int {
        P_LOAD, P_SKIP, P_FLAG, P_LITLEN, P_LIT, P_INDEX,
        P_LONGSEL, P_OFFSET, P_MATCHLEN, P_COPY, P_DONE
    } phase_t;

    // one row of the directed stream; n_exp < 0 means the model decides
    typedef struct {
        logic       op;
        logic [7:0] pb;
        int         n_exp;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        opcode = OP_PUSH;
    logic [7:0]  packed_byte = 8'h00;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [7:0]  out_byte;
    logic [23:0] out_position;
    logic        burst_last;
    logic        more_pending;
    logic        finished;
    logic        bad_reference;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = 32'h0;
    logic [31:0] prdata;
    logic        pready;

    backward_lz_bitstream_depacker uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .opcode(opcode), .packed_byte(packed_byte),
        .out_valid(out_valid), .out_stall(out_stall),
        .out_byte(out_byte), .out_position(out_position),
        .burst_last(burst_last), .more_pending(more_pending),
        .finished(finished), .bad_reference(bad_reference),
        .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // ---------------------------------------------------------------
    // Local model of the depacker: register copies and decoder state
    // ---------------------------------------------------------------
    logic [3:0]  ow [4];
    logic [7:0]  skip_reg;
    logic [23:0] olen_reg;

    logic [7:0]  holder;
    int          nbits;
    logic [7:0]  skip_left;
    phase_t      ph;
    logic [14:0] fval;
    int          fleft;
    logic [23:0] run;
    logic [14:0] mdist;
    logic [23:0] remain;
    logic [7:0]  hist [HISTORY_DEPTH];
    logic        cap_pending;   // last step stopped on the burst cap

    result_t step_out[$];       // beats produced by the current step
    result_t pending_bytes[$];  // beats still owed by the block

    int errors = 0;
    int cycles = 0;
    int snd_pct = 0;
    int rcv_pct = 0;
    bit hold_req = 1'b0;

    function automatic logic [23:0] sat24(input logic [23:0] a, input logic [23:0] b);
        logic [24:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[24] ? 24'hFFFFFF : s[23:0];
    endfunction

    task automatic begin_field(input phase_t p, input int w);
        ph    = p;
        fval  = '0;
        fleft = w;
    endtask

    // write one unpacked byte at the next lower position
    task automatic store_byte(input logic [7:0] b, input logic bad);
        result_t r;
        logic [23:0] pos;
        pos = remain - 24'd1;
        hist[pos[14:0]] = b;
        remain = pos;
        r.out_byte      = b;
        r.out_position  = pos;
        r.burst_last    = 1'b0;
        r.more_pending  = 1'b0;
        r.finished      = (pos == 24'd0);
        r.bad_reference = bad;
        step_out.push_back(r);
        if (pos == 24'd0)
            ph = P_DONE;
    endtask

    task automatic close_field();
        case (ph)
            P_FLAG:
            begin
                if (fval == 0)
                begin
                    run = '0;
                    begin_field(P_LITLEN, 2);
                end
                else
                    begin_field(P_INDEX, 2);
            end
            P_LITLEN:
            begin
                run = sat24(run, 24'(fval));
                if (fval == 3)
                    begin_field(P_LITLEN, 2);
                else
                begin
                    run = sat24(run, 24'd1);
                    begin_field(P_LIT, 8);
                end
            end
            P_LIT:
            begin
                store_byte(fval[7:0], 1'b0);
                run = run - 24'd1;
                if (ph != P_DONE)
                begin
                    if (run == 0)
                        begin_field(P_INDEX, 2);
                    else
                        begin_field(P_LIT, 8);
                end
            end
            P_INDEX:
            begin
                run = 24'(fval) + 24'd1;
                if (fval == 3)
                    begin_field(P_LONGSEL, 1);
                else
                    begin_field(P_OFFSET, int'(ow[fval[1:0]]));
            end
            P_LONGSEL:
                begin_field(P_OFFSET, (fval == 0) ? 7 : int'(ow[3]));
            P_OFFSET:
            begin
                mdist = fval;
                if (run == 24'd4)
                    begin_field(P_MATCHLEN, 3);
                else
                begin
                    run = sat24(run, 24'd1);
                    ph  = P_COPY;
                end
            end
            default:
            begin
                run = sat24(run, 24'(fval));
                if (fval == 7)
                    begin_field(P_MATCHLEN, 3);
                else
                begin
                    run = sat24(run, 24'd1);
                    ph  = P_COPY;
                end
            end
        endcase
    endtask

    // work out the beats one accepted item causes and queue them
    task automatic depack_step(input logic op, input logic [7:0] pb, output int n);
        logic        capped;
        logic        ok;
        logic [23:0] pos;
        int unsigned src;
        capped = 1'b0;
        step_out.delete();
        if (ph == P_LOAD)
        begin
            skip_left = skip_reg;
            remain    = olen_reg;
            ph        = (olen_reg == 0) ? P_DONE : P_SKIP;
        end
        if (ph != P_DONE)
        begin
            // a push while bits are still held is dropped
            if (op == OP_PUSH && nbits == 0)
            begin
                holder = pb;
                nbits  = 8;
            end
            while (1)
            begin
                if (ph == P_DONE)
                    break;
                if (ph == P_COPY)
                begin
                    if (run == 0)
                    begin
                        begin_field(P_FLAG, 1);
                        continue;
                    end
                    if (step_out.size() >= MAX_BURST)
                    begin
                        capped = 1'b1;
                        break;
                    end
                    pos = remain - 24'd1;
                    src = int'(pos) + 1 + int'(mdist);
                    // source past the unpacked size reads as zero and is flagged
                    ok  = (src < int'(olen_reg));
                    store_byte(ok ? hist[src % HISTORY_DEPTH] : 8'h00, !ok);
                    run = run - 24'd1;
                    continue;
                end
                if (ph == P_SKIP)
                begin
                    if (skip_left == 0)
                    begin
                        begin_field(P_FLAG, 1);
                        continue;
                    end
                end
                else if (fleft == 0)
                begin
                    if (ph == P_LIT && step_out.size() >= MAX_BURST)
                    begin
                        capped = 1'b1;
                        break;
                    end
                    close_field();
                    continue;
                end
                if (nbits == 0)
                    break;
                // bits leave the holder LSB first, fields fill MSB first
                if (ph == P_SKIP)
                    skip_left = skip_left - 8'd1;
                else
                begin
                    fval  = {fval[13:0], holder[0]};
                    fleft = fleft - 1;
                end
                holder = holder >> 1;
                nbits  = nbits - 1;
            end
        end
        n = step_out.size();
        if (n > 0)
        begin
            step_out[n-1].burst_last   = 1'b1;
            step_out[n-1].more_pending = capped;
        end
        cap_pending = capped;
        foreach (step_out[i])
            pending_bytes.push_back(step_out[i]);
    endtask

    // ---------------------------------------------------------------
    // Register port: setup beat then access beat, block must be idle
    // ---------------------------------------------------------------
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(int'(idx) * 4);
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_OW_A:   ow[0]    = val[3:0];
            REG_OW_B:   ow[1]    = val[3:0];
            REG_OW_C:   ow[2]    = val[3:0];
            REG_OW_D:   ow[3]    = val[3:0];
            REG_SKIP:   skip_reg = val[7:0];
            REG_OUTLEN: olen_reg = val[23:0];
            default: ;
        endcase
    endtask

    task automatic set_widths(input int a, input int b, input int c, input int d);
        write_reg(REG_OW_A, 32'(a));
        write_reg(REG_OW_B, 32'(b));
        write_reg(REG_OW_C, 32'(c));
        write_reg(REG_OW_D, 32'(d));
    endtask

    // ---------------------------------------------------------------
    // Packed byte channel: optional idle gap, then hold until accepted.
    // Called at a rising edge; returns at the edge the beat is taken.
    // ---------------------------------------------------------------
    task automatic put_item(input logic op, input logic [7:0] pb, output int n);
        while ($urandom_range(99) < snd_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        packed_byte <= pb;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        depack_step(op, pb, n);
    endtask

    // drain everything owed, then let any result-free work finish
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (pending_bytes.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // random items; a capped burst is usually followed by a continue
    task automatic random_items(input int count);
        int  n;
        logic op;
        for (int i = 0; i < count; i++)
        begin
            if (cap_pending)
                op = ($urandom_range(99) < 80) ? OP_CONT : OP_PUSH;
            else
                op = ($urandom_range(99) < 10) ? OP_CONT : OP_PUSH;
            put_item(op, 8'($urandom_range(255)), n);
        end
    endtask

    // ---------------------------------------------------------------
    // Receiver: stalls at random, or holds off for a long stretch
    // ---------------------------------------------------------------
    int hold_cnt = 0;

    always @(posedge clk)
    begin
        result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected beat byte=%h pos=%0d", $time,
                         out_byte, out_position);
                errors++;
            end
            else
            begin
                e = pending_bytes.pop_front();
                if (out_byte !== e.out_byte)
                begin
                    $display("%0t: out_byte exp %h got %h (pos %0d)", $time,
                             e.out_byte, out_byte, e.out_position);
                    errors++;
                end
                if (out_position !== e.out_position)
                begin
                    $display("%0t: out_position exp %0d got %0d", $time,
                             e.out_position, out_position);
                    errors++;
                end
                if (burst_last !== e.burst_last)
                begin
                    $display("%0t: burst_last exp %b got %b (pos %0d)", $time,
                             e.burst_last, burst_last, e.out_position);
                    errors++;
                end
                if (more_pending !== e.more_pending)
                begin
                    $display("%0t: more_pending exp %b got %b (pos %0d)", $time,
                             e.more_pending, more_pending, e.out_position);
                    errors++;
                end
                if (finished !== e.finished)
                begin
                    $display("%0t: finished exp %b got %b (pos %0d)", $time,
                             e.finished, finished, e.out_position);
                    errors++;
                end
                if (bad_reference !== e.bad_reference)
                begin
                    $display("%0t: bad_reference exp %b got %b (pos %0d)", $time,
                             e.bad_reference, bad_reference, e.out_position);
                    errors++;
                end
            end
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else if (hold_req)
        begin
            hold_req  = 1'b0;
            hold_cnt  = HOLD_CYCLES;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < rcv_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Directed stream. Bits go LSB first, so each byte is its stream
    // chunk reversed. Skip 13 bits, a four byte literal run of
    // 0xFF 0x00 0xA5 0x5A, then a long match with offset 0 whose
    // length extends nine times to 68, which trips the 64 beat cap.
    // A push while bits are still held is dropped and acts as continue.
    // ---------------------------------------------------------------
    row_t dir_rows [17] = '{
        '{OP_PUSH, 8'h35, 0},   // skip bits only
        '{OP_PUSH, 8'hCB, 0},   // end of skip, literal flag, length field 3
        '{OP_PUSH, 8'hFC, 0},   // length ends, first literal begins
        '{OP_PUSH, 8'h03, 1},   // 0xFF out
        '{OP_PUSH, 8'h94, 1},   // 0x00 out
        '{OP_PUSH, 8'h6A, 1},   // 0xA5 out
        '{OP_PUSH, 8'h0D, 1},   // 0x5A out, then index 3 and offset start
        '{OP_PUSH, 8'hF0, 0},
        '{OP_PUSH, 8'hFF, 0},
        '{OP_PUSH, 8'hFF, 0},
        '{OP_PUSH, 8'h7F, 0},
        '{OP_PUSH, 8'h04, 64},  // match length closes: capped burst
        '{OP_PUSH, 8'hFF, 4},   // dropped push drains the rest of the copy
        '{OP_PUSH, 8'h00, -1},
        '{OP_PUSH, 8'h01, -1},
        '{OP_CONT, 8'h00, -1},
        '{OP_PUSH, 8'hFF, -1}
    };

    initial
    begin
        int n;
        int guard;
        ow[0] = 4'd9; ow[1] = 4'd10; ow[2] = 4'd11; ow[3] = 4'd11;
        skip_reg = 8'd0; olen_reg = 24'd0;
        holder = '0; nbits = 0; skip_left = '0; ph = P_LOAD;
        fval = '0; fleft = 0; run = '0; mdist = '0; remain = '0;
        cap_pending = 1'b0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // counters load from these on the first item
        set_widths(9, 10, 11, 11);
        write_reg(REG_SKIP, 32'd13);
        write_reg(REG_OUTLEN, 32'd800);

        snd_pct = 10;
        rcv_pct = 61;
        foreach (dir_rows[i])
        begin
            put_item(dir_rows[i].op, dir_rows[i].pb, n);
            if (dir_rows[i].n_exp >= 0 && n != dir_rows[i].n_exp)
            begin
                $display("%0t: row %0d beat count exp %0d got %0d", $time, i,
                         dir_rows[i].n_exp, n);
                errors++;
            end
        end
        random_items(RAND_ITEMS);
        wait_idle();

        // narrowest and widest offsets; skip has no effect once loaded
        set_widths(1, 15, 4, 15);
        write_reg(REG_SKIP, 32'd255);
        write_reg(REG_OUTLEN, 32'd0);   // every copy now counts as bad
        snd_pct = 61;
        rcv_pct = 10;
        random_items(RAND_ITEMS);
        wait_idle();

        set_widths(15, 1, 7, 1);
        write_reg(REG_SKIP, 32'd0);
        write_reg(REG_OUTLEN, 32'd800);
        snd_pct = 0;
        rcv_pct = 0;
        // receiver holds off long enough for the block to back up
        hold_req = 1'b1;
        random_items(RAND_ITEMS);

        // zero bytes decode to short literal/copy pairs until position 0
        guard = 0;
        while (ph != P_DONE && guard < 2000)
        begin
            put_item(cap_pending ? OP_CONT : OP_PUSH, 8'h00, n);
            guard++;
        end
        // nothing comes out once decoding has finished
        put_item(OP_PUSH, 8'hA5, n);
        put_item(OP_CONT, 8'h00, n);
        wait_idle();

        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
